// ===== rtl/zfr_pkg.sv =====
// shared constants, types and crc helpers for the zmodem frame receiver
// no dependencies; used by every module under rtl
`default_nettype none
package zfr_pkg;

   localparam logic [7:0] ZPAD       = 8'h2a;
   localparam logic [7:0] ZDLE       = 8'h18;
   localparam logic [7:0] ESC_FLIP   = 8'h40;
   localparam logic [7:0] ESC_RUBOUT = 8'h7f;
   localparam logic [7:0] ESC_ONES   = 8'hff;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_C     = 8'h43;
   localparam logic [7:0] CHAR_H     = 8'h68;
   localparam logic [7:0] CHAR_K     = 8'h6b;
   localparam logic [7:0] CHAR_L     = 8'h6c;
   localparam logic [7:0] CHAR_M     = 8'h6d;
   localparam logic [31:0] CRC32_GOOD = 32'hdebb20e3;
   localparam logic [15:0] CRC16_POLY = 16'h1021;
   localparam logic [31:0] CRC32_POLY = 32'hedb88320;

   localparam logic [2:0]  CANCEL_RESET = 3'd5;
   localparam logic [10:0] DATA_RESET   = 11'd1524;

   localparam int QDepth = 4;
   localparam int QAw    = $clog2(QDepth);

   typedef enum logic [0:0] {
      REG_CANCEL_LIMIT = 1'b0,
      REG_DATA_LIMIT   = 1'b1
   } reg_index_type;

   typedef enum logic [3:0] {
      K_NONE     = 4'd0,
      K_HDR_OK   = 4'd1,
      K_HDR_CRC  = 4'd2,
      K_BAD_HEX  = 4'd3,
      K_DATA     = 4'd4,
      K_END      = 4'd5,
      K_LOST     = 4'd6,
      K_ABORT    = 4'd7,
      K_MISMATCH = 4'd8
   } kind_type;

   typedef enum logic [1:0] {
      FMT_HEX16 = 2'd0,
      FMT_BIN16 = 2'd1,
      FMT_BIN32 = 2'd2
   } format_type;

   typedef enum logic [2:0] {
      PH_PAD    = 3'd0,
      PH_DLE    = 3'd1,
      PH_LETTER = 3'd2,
      PH_BIN    = 3'd3,
      PH_HEX    = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      DM_OFF  = 2'd0,
      DM_INFO = 2'd1,
      DM_FILE = 2'd2
   } data_mode_type;

   typedef enum logic [1:0] {
      SS_RUN   = 2'd0,
      SS_EOF   = 2'd1,
      SS_DONE  = 2'd2,
      SS_ABORT = 2'd3
   } session_type;

   localparam logic [7:0] T_ZFILE = 8'd4;
   localparam logic [7:0] T_ZFIN  = 8'd8;
   localparam logic [7:0] T_ZDATA = 8'd10;
   localparam logic [7:0] T_ZEOF  = 8'd11;

   // classified link byte as it travels from front to back
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       is_zdle;
      logic       is_pad;
      logic       is_letter;
      logic       is_end;
      logic       hex_ok;
      logic [3:0] hex_val;
   } class_type;

   function automatic logic [15:0] crc16_upd(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] crc32_upd(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] b);
      logic [7:0] r;
      if (b == CHAR_L) begin
         r = ESC_RUBOUT;
      end else if (b == CHAR_M) begin
         r = ESC_ONES;
      end else begin
         r = b ^ ESC_FLIP;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/zfr_classify.sv =====
// front decode: tags each received byte with the codes the engine branches on
// depends on zfr_pkg
`default_nettype none
module zfr_classify (
   input  wire logic [7:0]         rx_byte,
   output zfr_pkg::class_type      cls
);

   always_comb begin
      cls          = '0;
      cls.rx_byte  = rx_byte;
      cls.is_zdle  = (rx_byte == zfr_pkg::ZDLE);
      cls.is_pad   = (rx_byte == zfr_pkg::ZPAD);
      cls.is_letter = (rx_byte >= zfr_pkg::CHAR_A) && (rx_byte <= zfr_pkg::CHAR_C);
      cls.is_end   = (rx_byte >= zfr_pkg::CHAR_H) && (rx_byte <= zfr_pkg::CHAR_K);
      if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
         cls.hex_ok  = 1'b1;
         cls.hex_val = rx_byte[3:0];
      end else if (rx_byte >= 8'h61 && rx_byte <= 8'h66) begin
         cls.hex_ok  = 1'b1;
         cls.hex_val = rx_byte[3:0] + 4'd9;
      end else if (rx_byte >= 8'h41 && rx_byte <= 8'h46) begin
         cls.hex_ok  = 1'b1;
         cls.hex_val = rx_byte[3:0] + 4'd9;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/zfr_queue.sv =====
// short fifo of classified bytes between the front decode and the engine
// depends on zfr_pkg
`default_nettype none
module zfr_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  zfr_pkg::class_type      push_data,
   output logic                    full,
   output logic                    not_empty,
   input  wire logic               pop,
   output zfr_pkg::class_type      pop_data
);

   zfr_pkg::class_type mem_ff [zfr_pkg::QDepth];
   logic [zfr_pkg::QAw-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [zfr_pkg::QAw:0]   count_ff, count_in;

   assign full      = (count_ff == (zfr_pkg::QAw+1)'(zfr_pkg::QDepth));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (zfr_pkg::QAw+1)'(push) - (zfr_pkg::QAw+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/zfr_engine.sv =====
// back end: hunt, header decode, data path and the registered result
// depends on zfr_pkg
`default_nettype none
module zfr_engine (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [0:0]         csr_index,
   input  wire logic [10:0]        csr_wdata,
   input  wire logic               in_valid,
   input  zfr_pkg::class_type      in_cls,
   output logic                    in_take,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_kind,
   output logic [7:0]              rsp_header_type,
   output logic [31:0]             rsp_header_param,
   output logic [7:0]              rsp_data_byte,
   output logic [1:0]              rsp_end_kind,
   output logic                    rsp_crc_ok,
   output logic [10:0]             rsp_subpacket_len,
   output logic [31:0]             rsp_file_position,
   output logic [1:0]              rsp_session_phase
);

   logic [2:0]  cancel_limit_ff;
   logic [10:0] data_limit_ff;

   zfr_pkg::phase_type     hunt_ff, hunt_in;
   zfr_pkg::format_type    fmt_ff, fmt_in;
   logic                   esc_ff, esc_in;
   logic [10:0]            cnt_ff, cnt_in;
   logic [7:0]             hdr_ff [9];
   logic [31:0]            crc_ff, crc_in;
   logic [4:0]             hexh_ff, hexh_in;
   logic [2:0]             cancel_ff, cancel_in;
   logic [31:0]            pos_ff, pos_in;
   zfr_pkg::session_type   sess_ff, sess_in;
   zfr_pkg::data_mode_type dm_ff, dm_in;
   logic [2:0]             endseen_ff, endseen_in;
   logic [1:0]             tail_ff, tail_in;
   logic [7:0]             back1_ff, back2_ff;

   logic                   valid_ff;
   zfr_pkg::kind_type      kind_ff, kind_in;
   logic [7:0]             otype_ff, otype_in, odata_ff, odata_in;
   logic [31:0]            oparam_ff, oparam_in;
   logic [1:0]             oend_ff, oend_in;
   logic                   ook_ff, ook_in;
   logic [10:0]            olen_ff, olen_in;
   logic [31:0]            opos_ff;
   zfr_pkg::session_type   osess_ff;

   logic        fire;
   logic [7:0]  b;
   logic        do_letter, do_pad, hb_valid, have_ch, ok;
   logic [7:0]  hb_val, ch, htype;
   logic [31:0] hparam, crc_new;
   logic [15:0] crc16_new;
   logic [2:0]  cancel_base, cancel_next;
   logic [10:0] cnt_next;
   logic [3:0]  need;

   assign fire    = in_valid && (!valid_ff || !rsp_stall);
   assign in_take = fire;
   assign b       = in_cls.rx_byte;

   always_comb begin
      hunt_in = hunt_ff;  fmt_in = fmt_ff;  esc_in = esc_ff;  cnt_in = cnt_ff;
      crc_in = crc_ff;  hexh_in = hexh_ff;  cancel_in = cancel_ff;  pos_in = pos_ff;
      sess_in = sess_ff;  dm_in = dm_ff;  endseen_in = endseen_ff;  tail_in = tail_ff;
      kind_in = zfr_pkg::K_NONE;
      otype_in = '0;  oparam_in = '0;  odata_in = '0;  oend_in = '0;  ook_in = 1'b0;
      olen_in = '0;
      do_letter = 1'b0;  do_pad = 1'b0;  hb_valid = 1'b0;  hb_val = '0;
      have_ch = 1'b0;  ch = '0;  ok = 1'b0;  cancel_base = cancel_ff;
      crc_new = '0;  crc16_new = '0;  cnt_next = '0;  cancel_next = '0;
      need = '0;  htype = '0;  hparam = '0;

      if (dm_ff != zfr_pkg::DM_OFF) begin
         if (esc_ff && in_cls.is_letter && back2_ff == zfr_pkg::ZPAD) begin
            // header start inside data leaves data mode silently
            dm_in = zfr_pkg::DM_OFF;
            esc_in = 1'b0;
            cancel_in = '0;
            cancel_base = '0;
            do_letter = 1'b1;
         end else begin
            if (esc_ff) begin
               esc_in = 1'b0;
               if (in_cls.is_end) begin
                  crc_in = {16'h0, zfr_pkg::crc16_upd(crc_ff[15:0], b)};
                  endseen_in = {1'b0, b[1:0]} + 3'd1;
                  tail_in = '0;
               end else begin
                  ch = zfr_pkg::unescape(b);
                  have_ch = 1'b1;
               end
            end else if (in_cls.is_zdle) begin
               esc_in = 1'b1;
            end else begin
               ch = b;
               have_ch = 1'b1;
            end
            if (have_ch) begin
               crc16_new = zfr_pkg::crc16_upd(crc_ff[15:0], ch);
               crc_in = {16'h0, crc16_new};
               if (endseen_ff != '0) begin
                  tail_in = tail_ff + 2'd1;
                  if (tail_ff != '0) begin
                     ok = (crc16_new == '0);
                     kind_in = zfr_pkg::K_END;
                     oend_in = 2'(endseen_ff - 3'd1);
                     ook_in = ok;
                     olen_in = cnt_ff;
                     if (dm_ff == zfr_pkg::DM_FILE && ok) begin
                        pos_in = pos_ff + {21'h0, cnt_ff};
                     end
                     if (!ok || endseen_ff == 3'd1 || endseen_ff == 3'd4) begin
                        dm_in = zfr_pkg::DM_OFF;
                        hunt_in = zfr_pkg::PH_PAD;
                     end else begin
                        cnt_in = '0;  endseen_in = '0;  tail_in = '0;
                        esc_in = 1'b0;  crc_in = '0;
                     end
                  end
               end else begin
                  cnt_next = cnt_ff + 11'd1;
                  cnt_in = cnt_next;
                  if (cnt_next >= data_limit_ff) begin
                     kind_in = zfr_pkg::K_LOST;
                     olen_in = cnt_next;
                     dm_in = zfr_pkg::DM_OFF;
                     hunt_in = zfr_pkg::PH_PAD;
                  end else begin
                     kind_in = zfr_pkg::K_DATA;
                     odata_in = ch;
                  end
               end
            end
         end
      end else begin
         unique case (hunt_ff)
            zfr_pkg::PH_DLE: begin
               if (in_cls.is_zdle) begin
                  hunt_in = zfr_pkg::PH_LETTER;
               end else begin
                  do_pad = 1'b1;
               end
            end
            zfr_pkg::PH_LETTER: begin
               do_letter = 1'b1;
            end
            zfr_pkg::PH_BIN: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  hb_valid = 1'b1;
                  hb_val = zfr_pkg::unescape(b);
               end else if (in_cls.is_zdle) begin
                  esc_in = 1'b1;
               end else begin
                  hb_valid = 1'b1;
                  hb_val = b;
               end
            end
            zfr_pkg::PH_HEX: begin
               if (!in_cls.hex_ok) begin
                  hunt_in = zfr_pkg::PH_PAD;
                  kind_in = zfr_pkg::K_BAD_HEX;
               end else if (hexh_ff[4]) begin
                  hexh_in = '0;
                  hb_valid = 1'b1;
                  hb_val = {hexh_ff[3:0], in_cls.hex_val};
               end else begin
                  hexh_in = {1'b1, in_cls.hex_val};
               end
            end
            default: begin
               hunt_in = zfr_pkg::PH_PAD;
               do_pad = 1'b1;
            end
         endcase
      end

      if (do_letter) begin
         if (in_cls.is_letter) begin
            unique case (b[1:0])
               2'd1:    fmt_in = zfr_pkg::FMT_BIN16;
               2'd3:    fmt_in = zfr_pkg::FMT_BIN32;
               default: fmt_in = zfr_pkg::FMT_HEX16;
            endcase
            hunt_in = (b[1:0] == 2'd2) ? zfr_pkg::PH_HEX : zfr_pkg::PH_BIN;
            cnt_in = '0;
            esc_in = 1'b0;
            hexh_in = '0;
            crc_in = (b[1:0] == 2'd3) ? 32'hffffffff : 32'h0;
         end else begin
            // the zdle before a bad letter counts as one cancel
            hunt_in = zfr_pkg::PH_PAD;
            if (cancel_limit_ff <= 3'd1) begin
               cancel_in = '0;
               sess_in = zfr_pkg::SS_ABORT;
               kind_in = zfr_pkg::K_ABORT;
            end else begin
               cancel_in = 3'd1;
               cancel_base = 3'd1;
               do_pad = 1'b1;
            end
         end
      end

      if (do_pad) begin
         if (in_cls.is_zdle) begin
            cancel_next = cancel_base + 3'd1;
            if (cancel_next >= cancel_limit_ff) begin
               cancel_in = '0;
               sess_in = zfr_pkg::SS_ABORT;
               kind_in = zfr_pkg::K_ABORT;
            end else begin
               cancel_in = cancel_next;
            end
         end else begin
            cancel_in = '0;
            hunt_in = in_cls.is_pad ? zfr_pkg::PH_DLE : zfr_pkg::PH_PAD;
         end
      end

      if (hb_valid) begin
         need = (fmt_ff == zfr_pkg::FMT_BIN32) ? 4'd9 : 4'd7;
         if (fmt_ff == zfr_pkg::FMT_BIN32) begin
            crc_new = zfr_pkg::crc32_upd(crc_ff, hb_val);
         end else begin
            crc_new = {16'h0, zfr_pkg::crc16_upd(crc_ff[15:0], hb_val)};
         end
         crc_in = crc_new;
         cnt_next = cnt_ff + 11'd1;
         cnt_in = cnt_next;
         if (cnt_next >= {7'h0, need}) begin
            hunt_in = zfr_pkg::PH_PAD;
            ok = (fmt_ff == zfr_pkg::FMT_BIN32) ? (crc_new == zfr_pkg::CRC32_GOOD)
                                                : (crc_new[15:0] == '0);
            htype = hdr_ff[0];
            hparam = {hdr_ff[4], hdr_ff[3], hdr_ff[2], hdr_ff[1]};
            if (!ok) begin
               kind_in = zfr_pkg::K_HDR_CRC;
            end else begin
               otype_in = htype;
               oparam_in = hparam;
               kind_in = zfr_pkg::K_HDR_OK;
               if (htype == zfr_pkg::T_ZFILE) begin
                  pos_in = '0;
                  if (fmt_ff == zfr_pkg::FMT_BIN16) begin
                     dm_in = zfr_pkg::DM_INFO;
                     cnt_in = '0;  endseen_in = '0;  tail_in = '0;
                     esc_in = 1'b0;  crc_in = '0;
                  end
               end else if (htype == zfr_pkg::T_ZDATA) begin
                  if (hparam != pos_ff) begin
                     kind_in = zfr_pkg::K_MISMATCH;
                  end else if (fmt_ff == zfr_pkg::FMT_BIN16) begin
                     dm_in = zfr_pkg::DM_FILE;
                     cnt_in = '0;  endseen_in = '0;  tail_in = '0;
                     esc_in = 1'b0;  crc_in = '0;
                  end
               end else if (htype == zfr_pkg::T_ZEOF) begin
                  if (hparam != pos_ff) begin
                     kind_in = zfr_pkg::K_MISMATCH;
                  end else begin
                     sess_in = zfr_pkg::SS_EOF;
                  end
               end else if (htype == zfr_pkg::T_ZFIN) begin
                  if (sess_ff == zfr_pkg::SS_EOF) begin
                     sess_in = zfr_pkg::SS_DONE;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && hb_valid && cnt_ff < 11'd9) begin
         hdr_ff[cnt_ff[3:0]] <= hb_val;
      end
      if (fire) begin
         otype_ff  <= otype_in;
         oparam_ff <= oparam_in;
         odata_ff  <= odata_in;
         oend_ff   <= oend_in;
         ook_ff    <= ook_in;
         olen_ff   <= olen_in;
         opos_ff   <= pos_in;
         osess_ff  <= sess_in;
      end
      if (reset) begin
         cancel_limit_ff <= zfr_pkg::CANCEL_RESET;
         data_limit_ff   <= zfr_pkg::DATA_RESET;
         hunt_ff    <= zfr_pkg::PH_PAD;
         fmt_ff     <= zfr_pkg::FMT_HEX16;
         esc_ff     <= 1'b0;
         cnt_ff     <= '0;
         crc_ff     <= '0;
         hexh_ff    <= '0;
         cancel_ff  <= '0;
         pos_ff     <= '0;
         sess_ff    <= zfr_pkg::SS_RUN;
         dm_ff      <= zfr_pkg::DM_OFF;
         endseen_ff <= '0;
         tail_ff    <= '0;
         back1_ff   <= '0;
         back2_ff   <= '0;
         valid_ff   <= 1'b0;
         kind_ff    <= zfr_pkg::K_NONE;
      end else begin
         if (csr_we) begin
            unique case (zfr_pkg::reg_index_type'(csr_index))
               zfr_pkg::REG_CANCEL_LIMIT: cancel_limit_ff <= csr_wdata[2:0];
               zfr_pkg::REG_DATA_LIMIT:   data_limit_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (fire) begin
            hunt_ff    <= hunt_in;
            fmt_ff     <= fmt_in;
            esc_ff     <= esc_in;
            cnt_ff     <= cnt_in;
            crc_ff     <= crc_in;
            hexh_ff    <= hexh_in;
            cancel_ff  <= cancel_in;
            pos_ff     <= pos_in;
            sess_ff    <= sess_in;
            dm_ff      <= dm_in;
            endseen_ff <= endseen_in;
            tail_ff    <= tail_in;
            back1_ff   <= b;
            back2_ff   <= back1_ff;
            kind_ff    <= kind_in;
            valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff   <= 1'b0;
         end
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_header_type   = otype_ff;
   assign rsp_header_param  = oparam_ff;
   assign rsp_data_byte     = odata_ff;
   assign rsp_end_kind      = oend_ff;
   assign rsp_crc_ok        = ook_ff;
   assign rsp_subpacket_len = olen_ff;
   assign rsp_file_position = opos_ff;
   assign rsp_session_phase = osess_ff;

endmodule
`default_nettype wire

// ===== rtl/zmodem_frame_receiver_core.sv =====
// zmodem receive deframer: one link byte in, one result item out per byte
// uses zfr_pkg, zfr_classify, zfr_queue, zfr_engine
//
// req channel: one received link byte per item (req_rx_byte), taken when
//   req_valid is high and req_stall is low. each byte gives exactly one
//   rsp item: header results, data bytes, subpacket ends, lost subpackets, aborts or none.
// csr port: csr_we with csr_index 0 (cancel limit) or 1 (data limit);
//   written by the user only while the block is idle; the block has no check.
// throughput: one item per cycle sustained while rsp is not stalled. the byte
//   is decoded on entry, parked in a 4-entry queue, and the engine does the
//   whole per-byte step (crc update and state change) into the rsp register.
// an accepted byte goes first into the queue, then into the rsp register.
// reset (synchronous): hunting for a header pad, session running, position
//   zero, limits back to 5 and 1524; the queue and rsp register empty.
// rsp stall: the rsp item holds; the engine stops and the queue fills,
//   and req_stall rises once the queue is full.
`default_nettype none
module zmodem_frame_receiver_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [10:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_kind,
   output logic [7:0]       rsp_header_type,
   output logic [31:0]      rsp_header_param,
   output logic [7:0]       rsp_data_byte,
   output logic [1:0]       rsp_end_kind,
   output logic             rsp_crc_ok,
   output logic [10:0]      rsp_subpacket_len,
   output logic [31:0]      rsp_file_position,
   output logic [1:0]       rsp_session_phase
);

   zfr_pkg::class_type front_cls, back_cls;
   logic q_full, q_ne, take;

   zfr_classify u_classify (
      .rx_byte (req_rx_byte),
      .cls     (front_cls)
   );

   zfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_data (front_cls),
      .full      (q_full),
      .not_empty (q_ne),
      .pop       (take),
      .pop_data  (back_cls)
   );

   zfr_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .in_valid          (q_ne),
      .in_cls            (back_cls),
      .in_take           (take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_header_type   (rsp_header_type),
      .rsp_header_param  (rsp_header_param),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_end_kind      (rsp_end_kind),
      .rsp_crc_ok        (rsp_crc_ok),
      .rsp_subpacket_len (rsp_subpacket_len),
      .rsp_file_position (rsp_file_position),
      .rsp_session_phase (rsp_session_phase)
   );

   assign req_stall = q_full;

   // an abort always leaves the session aborted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == zfr_pkg::K_ABORT |-> rsp_session_phase == zfr_pkg::SS_ABORT)
      else $error("abort without aborted session");

   // payload byte only shows for data items
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != zfr_pkg::K_DATA |-> rsp_data_byte == 8'h00)
      else $error("data byte set on non-data item");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the engine never takes from an empty queue
   assert property (@(posedge clock) disable iff (reset) take |-> q_ne)
      else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for zmodem_frame_receiver_core: directed and random link bytes
// depends on rtl/zfr_pkg.sv and rtl/zmodem_frame_receiver_core.sv
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  htype;
      logic [31:0] hparam;
      logic [7:0]  dbyte;
      logic [1:0]  ekind;
      logic        crc_ok;
      logic [10:0] splen;
      logic [31:0] fpos;
      logic [1:0]  sphase;
   } zresult_type;

   // behavioral deframer, kept in step with accepted link bytes
   class deframe_board;
      logic [2:0]  cancel_lim;
      logic [10:0] data_lim;
      zfr_pkg::phase_type   phase;
      zfr_pkg::format_type  fmt;
      logic        esc;
      logic [10:0] nbytes;
      logic [7:0]  hbytes[9];
      logic [31:0] crc;
      logic [4:0]  hexhi;
      logic [2:0]  ncancel;
      logic [31:0] pos;
      zfr_pkg::session_type sess;
      zfr_pkg::data_mode_type dmode;
      logic [2:0]  endseen;
      logic [7:0]  back1, back2;
      logic [1:0]  ntail;
      zresult_type r;
      zresult_type pending[$];
      int          errors;

      function new();
         cancel_lim = zfr_pkg::CANCEL_RESET; data_lim = zfr_pkg::DATA_RESET;
         phase = zfr_pkg::PH_PAD; fmt = zfr_pkg::FMT_HEX16; esc = 0; nbytes = 0;
         crc = 0; hexhi = 0;
         ncancel = 0; pos = 0; sess = zfr_pkg::SS_RUN; dmode = zfr_pkg::DM_OFF; endseen = 0;
         back1 = 0; back2 = 0; ntail = 0; errors = 0;
         foreach (hbytes[i]) hbytes[i] = 0;
      endfunction

      function logic [15:0] c16(logic [15:0] c, logic [7:0] b);
         c = c ^ {b, 8'h00};
         for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
         return c;
      endfunction

      function logic [31:0] c32(logic [31:0] c, logic [7:0] b);
         c = c ^ {24'h0, b};
         for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hedb88320) : (c >> 1);
         return c;
      endfunction

      function logic [7:0] unesc(logic [7:0] b);
         if (b == zfr_pkg::CHAR_L) return zfr_pkg::ESC_RUBOUT;
         if (b == zfr_pkg::CHAR_M) return zfr_pkg::ESC_ONES;
         return b ^ zfr_pkg::ESC_FLIP;
      endfunction

      function int hexval(logic [7:0] b);
         if (b >= "0" && b <= "9") return b - "0";
         if (b >= "a" && b <= "f") return b - "a" + 10;
         if (b >= "A" && b <= "F") return b - "A" + 10;
         return -1;
      endfunction

      function zfr_pkg::kind_type pad_byte(logic [7:0] b);
         if (b == zfr_pkg::ZDLE) begin
            ncancel = ncancel + 1;
            if (ncancel >= cancel_lim) begin
               ncancel = 0; sess = zfr_pkg::SS_ABORT; return zfr_pkg::K_ABORT;
            end
            return zfr_pkg::K_NONE;
         end
         ncancel = 0;
         phase = (b == zfr_pkg::ZPAD) ? zfr_pkg::PH_DLE : zfr_pkg::PH_PAD;
         return zfr_pkg::K_NONE;
      endfunction

      function void start_header(zfr_pkg::format_type f);
         fmt = f;
         phase = (f == zfr_pkg::FMT_HEX16) ? zfr_pkg::PH_HEX : zfr_pkg::PH_BIN;
         nbytes = 0; esc = 0; hexhi = 0;
         crc = (f == zfr_pkg::FMT_BIN32) ? 32'hffffffff : 32'h0;
      endfunction

      function zfr_pkg::kind_type letter_byte(logic [7:0] b);
         if (b == zfr_pkg::CHAR_A) begin
            start_header(zfr_pkg::FMT_BIN16); return zfr_pkg::K_NONE;
         end
         if (b == zfr_pkg::CHAR_B) begin
            start_header(zfr_pkg::FMT_HEX16); return zfr_pkg::K_NONE;
         end
         if (b == zfr_pkg::CHAR_C) begin
            start_header(zfr_pkg::FMT_BIN32); return zfr_pkg::K_NONE;
         end
         phase = zfr_pkg::PH_PAD;
         ncancel = 1;
         if (ncancel >= cancel_lim) begin
            ncancel = 0; sess = zfr_pkg::SS_ABORT; return zfr_pkg::K_ABORT;
         end
         return pad_byte(b);
      endfunction

      function void open_data(zfr_pkg::data_mode_type m);
         dmode = m; nbytes = 0; endseen = 0; ntail = 0; esc = 0; crc = 0;
      endfunction

      function zfr_pkg::kind_type finish_header();
         logic good;
         logic [31:0] prm;
         good = (fmt == zfr_pkg::FMT_BIN32) ? (crc == zfr_pkg::CRC32_GOOD)
                                            : (crc[15:0] == 0);
         phase = zfr_pkg::PH_PAD;
         if (!good) return zfr_pkg::K_HDR_CRC;
         prm = {hbytes[4], hbytes[3], hbytes[2], hbytes[1]};
         r.htype = hbytes[0];
         r.hparam = prm;
         case (hbytes[0])
            zfr_pkg::T_ZFILE: begin
               pos = 0;
               if (fmt == zfr_pkg::FMT_BIN16) open_data(zfr_pkg::DM_INFO);
            end
            zfr_pkg::T_ZDATA: begin
               if (prm != pos) return zfr_pkg::K_MISMATCH;
               if (fmt == zfr_pkg::FMT_BIN16) open_data(zfr_pkg::DM_FILE);
            end
            zfr_pkg::T_ZEOF: begin
               if (prm != pos) return zfr_pkg::K_MISMATCH;
               sess = zfr_pkg::SS_EOF;
            end
            zfr_pkg::T_ZFIN: if (sess == zfr_pkg::SS_EOF) sess = zfr_pkg::SS_DONE;
            default: ;
         endcase
         return zfr_pkg::K_HDR_OK;
      endfunction

      function zfr_pkg::kind_type hdr_byte(logic [7:0] v);
         int need;
         need = (fmt == zfr_pkg::FMT_BIN32) ? 9 : 7;
         if (nbytes < 9) hbytes[nbytes] = v;
         crc = (fmt == zfr_pkg::FMT_BIN32) ? c32(crc, v) : {16'h0, c16(crc[15:0], v)};
         nbytes = nbytes + 1;
         if (nbytes >= need) return finish_header();
         return zfr_pkg::K_NONE;
      endfunction

      function zfr_pkg::kind_type data_byte(logic [7:0] b, logic [7:0] two_back);
         logic [7:0] ch;
         logic good;
         if (esc && b >= zfr_pkg::CHAR_A && b <= zfr_pkg::CHAR_C &&
             two_back == zfr_pkg::ZPAD) begin
            dmode = zfr_pkg::DM_OFF; esc = 0; ncancel = 0;
            return letter_byte(b);
         end
         if (esc) begin
            esc = 0;
            if (b >= zfr_pkg::CHAR_H && b <= zfr_pkg::CHAR_K) begin
               crc = {16'h0, c16(crc[15:0], b)};
               endseen = b - zfr_pkg::CHAR_H + 1;
               ntail = 0;
               return zfr_pkg::K_NONE;
            end
            ch = unesc(b);
         end else if (b == zfr_pkg::ZDLE) begin
            esc = 1;
            return zfr_pkg::K_NONE;
         end else begin
            ch = b;
         end
         crc = {16'h0, c16(crc[15:0], ch)};
         if (endseen != 0) begin
            ntail = ntail + 1;
            if (ntail < 2) return zfr_pkg::K_NONE;
            good = (crc[15:0] == 0);
            r.ekind = endseen - 1;
            r.crc_ok = good;
            r.splen = nbytes;
            if (dmode == zfr_pkg::DM_FILE && good) pos = pos + nbytes;
            if (!good || endseen == 1 || endseen == 4) begin
               dmode = zfr_pkg::DM_OFF; phase = zfr_pkg::PH_PAD;
            end else begin
               open_data(dmode);
            end
            return zfr_pkg::K_END;
         end
         nbytes = nbytes + 1;
         if (nbytes >= data_lim) begin
            r.splen = nbytes; dmode = zfr_pkg::DM_OFF; phase = zfr_pkg::PH_PAD;
            return zfr_pkg::K_LOST;
         end
         r.dbyte = ch;
         return zfr_pkg::K_DATA;
      endfunction

      function void note_byte(logic [7:0] b);
         zfr_pkg::kind_type k;
         int v;
         r = '0;
         k = zfr_pkg::K_NONE;
         if (dmode != zfr_pkg::DM_OFF) begin
            k = data_byte(b, back2);
         end else begin
            case (phase)
               zfr_pkg::PH_DLE: begin
                  if (b == zfr_pkg::ZDLE) phase = zfr_pkg::PH_LETTER; else k = pad_byte(b);
               end
               zfr_pkg::PH_LETTER: k = letter_byte(b);
               zfr_pkg::PH_BIN: begin
                  if (esc) begin
                     esc = 0; k = hdr_byte(unesc(b));
                  end else if (b == zfr_pkg::ZDLE) begin
                     esc = 1;
                  end else begin
                     k = hdr_byte(b);
                  end
               end
               zfr_pkg::PH_HEX: begin
                  v = hexval(b);
                  if (v < 0) begin
                     phase = zfr_pkg::PH_PAD; k = zfr_pkg::K_BAD_HEX;
                  end else if (hexhi[4]) begin
                     logic [7:0] hb;
                     hb = {hexhi[3:0], v[3:0]};
                     hexhi = 0;
                     k = hdr_byte(hb);
                  end else begin
                     hexhi = {1'b1, v[3:0]};
                  end
               end
               default: begin phase = zfr_pkg::PH_PAD; k = pad_byte(b); end
            endcase
         end
         back2 = back1;
         back1 = b;
         r.kind = k;
         r.fpos = pos;
         r.sphase = sess;
         pending.push_back(r);
      endfunction

      function void check(zresult_type got);
         zresult_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected item kind %0d", $time, got.kind);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            $display("%0t: mismatch exp kind=%0d typ=%h prm=%h db=%h ek=%0d ok=%0d %s",
                     $time, e.kind, e.htype, e.hparam, e.dbyte, e.ekind, e.crc_ok,
                     $sformatf("len=%0d pos=%h ph=%0d", e.splen, e.fpos, e.sphase));
            $display("%0t:          got kind=%0d typ=%h prm=%h db=%h ek=%0d ok=%0d %s",
                     $time, got.kind, got.htype, got.hparam, got.dbyte, got.ekind,
                     got.crc_ok,
                     $sformatf("len=%0d pos=%h ph=%0d", got.splen, got.fpos, got.sphase));
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0, reset = 1;
   logic        csr_we = 0;
   logic [0:0]  csr_index = zfr_pkg::REG_CANCEL_LIMIT;
   logic [10:0] csr_wdata = 0;
   logic        req_valid = 0, req_stall;
   logic [7:0]  req_rx_byte = 0;
   logic        rsp_valid, rsp_stall = 0;
   zresult_type got;

   zmodem_frame_receiver_core dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_valid(req_valid), .req_stall(req_stall),
      .req_rx_byte(req_rx_byte), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kind(got.kind), .rsp_header_type(got.htype), .rsp_header_param(got.hparam),
      .rsp_data_byte(got.dbyte), .rsp_end_kind(got.ekind), .rsp_crc_ok(got.crc_ok),
      .rsp_subpacket_len(got.splen), .rsp_file_position(got.fpos),
      .rsp_session_phase(got.sphase)
   );

   always #6 clock = ~clock;

   deframe_board board = new();
   logic [7:0] stream[$];
   int  cycles = 0;
   int  hold_cycles = 0;
   bit  rsp_random = 1;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check(got);
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1;
      end else if (!rsp_random) begin
         rsp_stall <= 0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 5) ? 1'b1 : ($urandom_range(0, 3) == 0);
      end
   end

   function int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   task automatic send_all(bit gaps);
      int g;
      while (stream.size() > 0) begin
         g = gaps ? gap_len() : 0;
         if (g > 0) begin
            req_valid <= 0;
            repeat (g) @(posedge clock);
         end
         req_valid <= 1;
         req_rx_byte <= stream[0];
         @(posedge clock);
         while (req_stall) @(posedge clock);
         board.note_byte(stream.pop_front());
      end
      req_valid <= 0;
   endtask

   task automatic drain();
      while (board.pending.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(zfr_pkg::reg_index_type idx, logic [10:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx == zfr_pkg::REG_CANCEL_LIMIT) board.cancel_lim = val[2:0];
      else board.data_lim = val;
   endtask

   // stream builders
   function void put_bin(logic [7:0] b);
      if (b == zfr_pkg::ZDLE || b == 8'h10 || b == 8'h90 || b == 8'h11 || b == 8'h91 ||
          b == 8'h13 || b == 8'h93 || b == zfr_pkg::ESC_RUBOUT || b == zfr_pkg::ESC_ONES ||
          ($urandom_range(0, 9) == 0)) begin
         stream.push_back(zfr_pkg::ZDLE);
         if (b == zfr_pkg::ESC_RUBOUT) stream.push_back(zfr_pkg::CHAR_L);
         else if (b == zfr_pkg::ESC_ONES) stream.push_back(zfr_pkg::CHAR_M);
         else stream.push_back(b ^ zfr_pkg::ESC_FLIP);
      end else begin
         stream.push_back(b);
      end
   endfunction

   function logic [7:0] hexch(logic [3:0] n);
      if (n < 10) return "0" + n;
      return ($urandom_range(0, 1) ? "a" : "A") + n - 10;
   endfunction

   function void put_header(int fmtsel, logic [7:0] typ, logic [31:0] prm, bit corrupt);
      logic [7:0] hb[5];
      logic [15:0] c16v;
      logic [31:0] c32v;
      hb[0] = typ; hb[1] = prm[7:0]; hb[2] = prm[15:8]; hb[3] = prm[23:16];
      hb[4] = prm[31:24];
      c16v = 0; c32v = 32'hffffffff;
      foreach (hb[i]) begin
         c16v = board.c16(c16v, hb[i]);
         c32v = board.c32(c32v, hb[i]);
      end
      if (corrupt) begin c16v ^= 16'h0100; c32v ^= 32'h1; end
      c32v = ~c32v;
      stream.push_back(zfr_pkg::ZPAD);
      if (fmtsel == 1) stream.push_back(zfr_pkg::ZPAD);
      stream.push_back(zfr_pkg::ZDLE);
      if (fmtsel == 0) begin
         stream.push_back(zfr_pkg::CHAR_A);
         foreach (hb[i]) put_bin(hb[i]);
         put_bin(c16v[15:8]); put_bin(c16v[7:0]);
      end else if (fmtsel == 1) begin
         stream.push_back(zfr_pkg::CHAR_B);
         foreach (hb[i]) begin
            stream.push_back(hexch(hb[i][7:4])); stream.push_back(hexch(hb[i][3:0]));
         end
         stream.push_back(hexch(c16v[15:12])); stream.push_back(hexch(c16v[11:8]));
         stream.push_back(hexch(c16v[7:4])); stream.push_back(hexch(c16v[3:0]));
      end else begin
         stream.push_back(zfr_pkg::CHAR_C);
         foreach (hb[i]) put_bin(hb[i]);
         put_bin(c32v[7:0]); put_bin(c32v[15:8]); put_bin(c32v[23:16]);
         put_bin(c32v[31:24]);
      end
   endfunction

   // crc over payload and terminator, sent high byte first, leaves a zero residue
   function void put_subpacket(int len, int term, bit corrupt);
      logic [15:0] c;
      logic [7:0] b;
      c = 0;
      for (int i = 0; i < len; i++) begin
         b = $urandom_range(0, 255);
         c = board.c16(c, b);
         put_bin(b);
      end
      c = board.c16(c, zfr_pkg::CHAR_H + term);
      if (corrupt) c ^= 16'h0001;
      stream.push_back(zfr_pkg::ZDLE);
      stream.push_back(zfr_pkg::CHAR_H + term);
      put_bin(c[15:8]); put_bin(c[7:0]);
   endfunction

   function void put_random_session();
      int n;
      logic [31:0] p;
      p = board.pos;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            put_header(0, zfr_pkg::T_ZFILE, $urandom, 0);
            put_subpacket($urandom_range(0, 12), 3, $urandom_range(0, 9) == 0);
            put_header(0, zfr_pkg::T_ZDATA, 0, 0);
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               put_subpacket($urandom_range(0, 20),
                             (i == n - 1) ? 0 : $urandom_range(1, 2),
                             $urandom_range(0, 12) == 0);
         end
         3: put_header(0, zfr_pkg::T_ZDATA, ($urandom_range(0, 1) ? p : $urandom), 0);
         4: put_header($urandom_range(0, 2), zfr_pkg::T_ZEOF,
                       ($urandom_range(0, 2) ? p : $urandom), 0);
         5: put_header($urandom_range(0, 2), zfr_pkg::T_ZFIN, $urandom, 0);
         6: put_header($urandom_range(0, 2), $urandom, $urandom, $urandom_range(0, 3) == 0);
         7: begin
            put_header(0, zfr_pkg::T_ZDATA, p, 0);
            put_subpacket($urandom_range(0, 6), 1, 0);
            // header arriving inside data mode
            put_header($urandom_range(0, 2), zfr_pkg::T_ZFIN, $urandom, 0);
         end
         8: repeat ($urandom_range(1, 8)) stream.push_back(zfr_pkg::ZDLE);
         default: repeat ($urandom_range(1, 10)) begin
            stream.push_back($urandom_range(0, 3) == 0 ? zfr_pkg::ZPAD
                                                       : $urandom_range(0, 255));
         end
      endcase
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: hex header with a bad digit, binary headers, cancel run
      put_header(1, zfr_pkg::T_ZFILE, 32'h0, 0);
      stream.push_back(zfr_pkg::ZPAD); stream.push_back(zfr_pkg::ZDLE);
      stream.push_back(zfr_pkg::CHAR_B);
      stream.push_back("g");
      stream.push_back(zfr_pkg::ZPAD); stream.push_back(zfr_pkg::ZDLE);
      stream.push_back(8'h00);
      repeat (5) stream.push_back(zfr_pkg::ZDLE);
      stream.push_back(8'hff);
      send_all(0);
      drain();
      put_header(0, zfr_pkg::T_ZFILE, 32'hffffffff, 0);
      put_subpacket(3, 2, 0);
      put_subpacket(2, 3, 0);
      put_header(2, zfr_pkg::T_ZEOF, 32'h0, 1);
      send_all(1);
      drain();

      // pressure: hold the receiver while bytes keep coming
      hold_cycles = 60;
      repeat (8) put_random_session();
      send_all(0);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(zfr_pkg::REG_CANCEL_LIMIT, 1); write_reg(zfr_pkg::REG_DATA_LIMIT, 2);
            end
            1: begin
               write_reg(zfr_pkg::REG_CANCEL_LIMIT, 7);
               write_reg(zfr_pkg::REG_DATA_LIMIT, 2047);
            end
            2: begin
               write_reg(zfr_pkg::REG_CANCEL_LIMIT, 0); write_reg(zfr_pkg::REG_DATA_LIMIT, 10);
            end
            3: begin
               write_reg(zfr_pkg::REG_CANCEL_LIMIT, 3);
               write_reg(zfr_pkg::REG_DATA_LIMIT, 1524);
            end
            4: begin
               write_reg(zfr_pkg::REG_CANCEL_LIMIT, 2); write_reg(zfr_pkg::REG_DATA_LIMIT, 17);
            end
            default: begin
               write_reg(zfr_pkg::REG_CANCEL_LIMIT, 5); write_reg(zfr_pkg::REG_DATA_LIMIT, 30);
            end
         endcase
         rsp_random = (ph != 3);
         while (stream.size() < 160) put_random_session();
         send_all(ph != 3);
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/zfr_pkg.sv
rtl/zfr_classify.sv
rtl/zfr_queue.sv
rtl/zfr_engine.sv
rtl/zmodem_frame_receiver_core.sv
tb/tb.sv
